// ===== rtl/core/gsfe_pkg.sv =====
// Package: shared types and constants for the gamepad report frame emitter.
`default_nettype none

package gsfe_pkg;

   // Report layout
   localparam int unsigned SlotCount   = 6;
   localparam int unsigned HeaderLen   = 3;
   localparam int unsigned FrameLen    = HeaderLen + SlotCount;
   localparam int unsigned SlotWidth   = 3;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CountWidth  = $clog2(FrameLen + 1);
   localparam int unsigned ButtonSlots = 2;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef byte_type report_type [SlotCount];

   // Frame header bytes
   localparam byte_type Header0 = 8'hFF;
   localparam byte_type Header1 = 8'h73;
   localparam byte_type Header2 = 8'h5A;

   // Rest values of the stick bytes; button bytes rest high (active low)
   localparam byte_type ButtonRest = 8'hFF;
   localparam byte_type StickCenterA = 8'h80;
   localparam byte_type StickCenterB = 8'h7F;

   // Request operations
   typedef enum logic [1:0] {
      OP_PRESS       = 2'd0,
      OP_RELEASE     = 2'd1,
      OP_ANALOG      = 2'd2,
      OP_RELEASE_ALL = 2'd3
   } op_type;

   // Rest value of one report slot
   function automatic byte_type rest_value(input int unsigned slot);
      byte_type result;
      if (slot < ButtonSlots) begin
         result = ButtonRest;
      end else if ((slot % 2) == 0) begin
         result = StickCenterA;
      end else begin
         result = StickCenterB;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gsfe_update.sv =====
// Report state registers and the request update logic.
`default_nettype none

module gsfe_update (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [1:0]                       opcode,
   input  wire logic [gsfe_pkg::SlotWidth-1:0]   slot_index,
   input  wire logic [gsfe_pkg::ByteWidth-1:0]   value,
   output gsfe_pkg::report_type                  report_in,
   output logic                                  emit
);
   import gsfe_pkg::*;

   report_type report_ff;
   op_type     op;
   logic       in_range;
   logic       is_button;

   assign op        = op_type'(opcode);
   assign in_range  = (slot_index < SlotWidth'(SlotCount));
   assign is_button = (slot_index < SlotWidth'(ButtonSlots));

   // Decide whether the request sends a frame
   always_comb begin
      unique case (op)
         OP_PRESS, OP_RELEASE: emit = is_button;
         OP_ANALOG:            emit = in_range && !is_button;
         OP_RELEASE_ALL:       emit = 1'b1;
         default:              emit = 1'b0;
      endcase
   end

   // Compute the next value of each slot
   always_comb begin
      for (int i = 0; i < SlotCount; i++) begin
         report_in[i] = report_ff[i];
         if (op == OP_RELEASE_ALL) begin
            report_in[i] = rest_value(i);
         end else if (slot_index == SlotWidth'(i)) begin
            unique case (op)
               OP_PRESS:   report_in[i] = report_ff[i] & ~value;
               OP_RELEASE: report_in[i] = report_ff[i] | value;
               OP_ANALOG:  report_in[i] = value;
               default:    report_in[i] = report_ff[i];
            endcase
         end
      end
   end

   // Hold the report; restore rest values on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SlotCount; i++) begin
            report_ff[i] <= rest_value(i);
         end
      end else if (accept) begin
         report_ff <= report_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gsfe_shifter.sv =====
// Nine-byte frame shift register that sends one byte per cycle while rsp_stall is low.
`default_nettype none

module gsfe_shifter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load,
   input  gsfe_pkg::report_type                  report,
   input  wire logic                             rsp_stall,
   output logic                                  busy,
   output logic [gsfe_pkg::ByteWidth-1:0]        frame_byte,
   output logic                                  last_byte
);
   import gsfe_pkg::*;

   byte_type                shift_ff [FrameLen];
   byte_type                shift_in [FrameLen];
   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic                    advance;

   assign busy       = (count_ff != '0);
   assign advance    = busy && !rsp_stall;
   assign frame_byte = shift_ff[0];
   assign last_byte  = (count_ff == CountWidth'(1));

   // Load header and report, or advance one byte
   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (load) begin
         shift_in[0] = Header0;
         shift_in[1] = Header1;
         shift_in[2] = Header2;
         for (int i = 0; i < SlotCount; i++) begin
            shift_in[HeaderLen + i] = report[i];
         end
         count_in = CountWidth'(FrameLen);
      end else if (advance) begin
         for (int k = 0; k < FrameLen - 1; k++) begin
            shift_in[k] = shift_ff[k + 1];
         end
         count_in = count_ff - CountWidth'(1);
      end
   end

   // Hold the payload bytes
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   // Track bytes left in the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gamepad_state_frame_emitter_unit.sv =====
// Top level of the gamepad report frame emitter.
`default_nettype none

// Keeps six controller report bytes (two active-low button bytes, four stick
// bytes) and applies one press, release, analog or release-all request at a
// time. A request that sends a frame loads a nine-byte shift register with
// header FF 73 5A and the updated report, and the frame leaves one byte per
// cycle while rsp_stall is low, last_byte marking the ninth. req_stall then stays
// high until the last byte has been taken, so the next request is taken only
// after the whole frame has left; the single byte-wide output of that shift
// register sets this. A request that sends no frame does not stall requests.
// After reset the report holds FF FF 80 7F 80 7F and the block is ready.
module gamepad_state_frame_emitter_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [gsfe_pkg::SlotWidth-1:0]   req_slot_index,
   input  wire logic [gsfe_pkg::ByteWidth-1:0]   req_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [gsfe_pkg::ByteWidth-1:0]        rsp_frame_byte,
   output logic                                  rsp_last_byte
);
   import gsfe_pkg::*;

   report_type report_in;
   logic       emit;
   logic       accept;
   logic       busy;

   // Take a request only while no frame is in flight
   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign rsp_valid = busy;

   gsfe_update u_update (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_opcode),
      .slot_index (req_slot_index),
      .value      (req_value),
      .report_in  (report_in),
      .emit       (emit)
   );

   gsfe_shifter u_shifter (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && emit),
      .report     (report_in),
      .rsp_stall  (rsp_stall),
      .busy       (busy),
      .frame_byte (rsp_frame_byte),
      .last_byte  (rsp_last_byte)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the gamepad report frame emitter: directed and random requests, frame checks.
`timescale 1ns / 1ps

// One expected byte of a report frame
typedef struct packed {
   gsfe_pkg::byte_type frame_byte;
   logic               last_byte;
} frame_entry_type;

// Tracks the controller report and the frame bytes still owed by the block
class frame_scoreboard;
   gsfe_pkg::byte_type report [gsfe_pkg::SlotCount];
   frame_entry_type    owed_bytes [$];
   int                 failures;

   function new();
      failures = 0;
      restore_rest();
   endfunction

   // Put every slot back to its resting value
   function void restore_rest();
      report[0] = gsfe_pkg::ButtonRest;
      report[1] = gsfe_pkg::ButtonRest;
      report[2] = gsfe_pkg::StickCenterA;
      report[3] = gsfe_pkg::StickCenterB;
      report[4] = gsfe_pkg::StickCenterA;
      report[5] = gsfe_pkg::StickCenterB;
   endfunction

   // Apply one accepted request and queue the frame it sends, if any
   function void note_request(gsfe_pkg::op_type op, logic [2:0] slot,
                              gsfe_pkg::byte_type val);
      bit              send;
      frame_entry_type entry;
      send = 1'b0;
      case (op)
         gsfe_pkg::OP_PRESS: begin
            if (slot < gsfe_pkg::SlotCount) begin
               report[slot] = report[slot] & ~val;
               send = (slot < gsfe_pkg::ButtonSlots);
            end
         end
         gsfe_pkg::OP_RELEASE: begin
            if (slot < gsfe_pkg::SlotCount) begin
               report[slot] = report[slot] | val;
               send = (slot < gsfe_pkg::ButtonSlots);
            end
         end
         gsfe_pkg::OP_ANALOG: begin
            if (slot < gsfe_pkg::SlotCount) begin
               report[slot] = val;
               send = (slot >= gsfe_pkg::ButtonSlots);
            end
         end
         default: begin
            restore_rest();
            send = 1'b1;
         end
      endcase
      if (send) begin
         entry.last_byte = 1'b0;
         entry.frame_byte = gsfe_pkg::Header0;
         owed_bytes.push_back(entry);
         entry.frame_byte = gsfe_pkg::Header1;
         owed_bytes.push_back(entry);
         entry.frame_byte = gsfe_pkg::Header2;
         owed_bytes.push_back(entry);
         for (int i = 0; i < gsfe_pkg::SlotCount; i++) begin
            entry.frame_byte = report[i];
            entry.last_byte = (i == gsfe_pkg::SlotCount - 1);
            owed_bytes.push_back(entry);
         end
      end
   endfunction

   // Compare one accepted frame byte with the oldest owed byte
   function void check_byte(gsfe_pkg::byte_type got_byte, logic got_last);
      frame_entry_type entry;
      if (owed_bytes.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected frame byte %h last %b", got_byte, got_last);
      end else begin
         entry = owed_bytes.pop_front();
         if (got_byte !== entry.frame_byte || got_last !== entry.last_byte) begin
            failures++;
            if (failures <= 10)
               $display("frame mismatch: byte exp %h got %h, last exp %b got %b",
                        entry.frame_byte, got_byte, entry.last_byte, got_last);
         end
      end
   endfunction

   function int pending();
      return owed_bytes.size();
   endfunction
endclass

module tb_top;
   localparam int WatchdogLimit = 2000;
   localparam int RandomCount   = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = '0;
   logic [2:0]         req_slot_index = '0;
   logic [7:0]         req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_last_byte;

   frame_scoreboard    board = new();
   bit                 no_idle = 1'b0;
   int                 idle_cycles = 0;
   int                 stall_left = 0;
   int                 rsp_gap;

   gamepad_state_frame_emitter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_slot_index (req_slot_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   always #2 clock = ~clock;

   // Idle cycles before the next request or after a result; none in burst stretches
   function automatic int draw_idle();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic send_request(input gsfe_pkg::op_type op, input logic [2:0] slot,
                               input logic [7:0] val);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_slot_index <= slot;
      req_value <= val;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_request(op, slot, val);
   endtask

   // Mostly well-formed button and stick updates, some noise
   task automatic send_random_request();
      int               pick;
      gsfe_pkg::op_type op;
      logic [2:0]       slot;
      logic [7:0]       val;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0: val = 8'h00;
         1: val = 8'hFF;
         default: val = 8'($urandom_range(0, 255));
      endcase
      if (pick < 30) begin
         op = gsfe_pkg::OP_PRESS;
         slot = 3'($urandom_range(0, 1));
      end else if (pick < 55) begin
         op = gsfe_pkg::OP_RELEASE;
         slot = 3'($urandom_range(0, 1));
      end else if (pick < 80) begin
         op = gsfe_pkg::OP_ANALOG;
         slot = 3'($urandom_range(2, 5));
      end else if (pick < 88) begin
         op = gsfe_pkg::OP_RELEASE_ALL;
         slot = 3'($urandom_range(0, 7));
      end else begin
         op = gsfe_pkg::op_type'($urandom_range(0, 3));
         slot = 3'($urandom_range(0, 7));
      end
      send_request(op, slot, val);
   endtask

   // Accept frame bytes and draw a stall after each one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         board.check_byte(rsp_frame_byte, rsp_last_byte);
         rsp_gap = draw_idle();
         stall_left <= rsp_gap;
         rsp_stall <= (rsp_gap != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Button bytes at the mask extremes
      send_request(gsfe_pkg::OP_PRESS, 3'd0, 8'hFF);
      send_request(gsfe_pkg::OP_RELEASE, 3'd0, 8'hFF);
      send_request(gsfe_pkg::OP_PRESS, 3'd1, 8'hA5);
      send_request(gsfe_pkg::OP_RELEASE, 3'd1, 8'h0F);
      send_request(gsfe_pkg::OP_PRESS, 3'd1, 8'h00);
      // Stick bytes at both ends and in alternating bit patterns
      send_request(gsfe_pkg::OP_ANALOG, 3'd2, 8'h00);
      send_request(gsfe_pkg::OP_ANALOG, 3'd3, 8'hFF);
      send_request(gsfe_pkg::OP_ANALOG, 3'd4, 8'h55);
      send_request(gsfe_pkg::OP_ANALOG, 3'd5, 8'hAA);
      // Analog write to a button slot stays silent, shows up in the next frame
      send_request(gsfe_pkg::OP_ANALOG, 3'd0, 8'h12);
      send_request(gsfe_pkg::OP_PRESS, 3'd0, 8'h00);
      // Press and release on stick slots update silently; a button release then sends them
      send_request(gsfe_pkg::OP_PRESS, 3'd3, 8'hF0);
      send_request(gsfe_pkg::OP_RELEASE, 3'd4, 8'h0F);
      send_request(gsfe_pkg::OP_RELEASE, 3'd1, 8'h00);
      // Out-of-range slots change nothing
      send_request(gsfe_pkg::OP_PRESS, 3'd6, 8'hFF);
      send_request(gsfe_pkg::OP_RELEASE, 3'd7, 8'hFF);
      send_request(gsfe_pkg::OP_ANALOG, 3'd6, 8'h00);
      send_request(gsfe_pkg::OP_ANALOG, 3'd7, 8'h33);
      send_request(gsfe_pkg::OP_PRESS, 3'd0, 8'h80);
      // Release all ignores slot and value
      send_request(gsfe_pkg::OP_RELEASE_ALL, 3'd7, 8'hFF);
      send_request(gsfe_pkg::OP_ANALOG, 3'd2, 8'h01);
      send_request(gsfe_pkg::OP_RELEASE_ALL, 3'd0, 8'h00);

      for (int i = 0; i < RandomCount; i++) begin
         if ($urandom_range(0, 15) == 0)
            no_idle = ~no_idle;
         send_random_request();
      end
      req_valid <= 1'b0;

      // Drain owed bytes, then allow the block to settle
      while (board.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
